// ===== src/crr_pkg.sv =====
package crr_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int STORE_BYTES = 1024;
	localparam int PLAYERS     = 4;
	localparam int MERGE_LIMIT = 32767;

	localparam int IDX_W = $clog2(MAX_ENTRIES);
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int OFS_W = 11;
	localparam int SA_W  = 12;

	typedef enum logic [1:0] {
		OP_REGISTER = 2'd0,
		OP_LOOKUP   = 2'd1,
		OP_FREEZE   = 2'd2
	} crr_op_t;

	typedef enum logic [2:0] {
		ST_COVERED   = 3'd0,
		ST_ADDED     = 3'd1,
		ST_REFUSED   = 3'd2,
		ST_FOUND     = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_FROZEN    = 3'd5
	} crr_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_EX,
		S_HIT_RD,
		S_HIT_EX,
		S_DECIDE,
		S_APPEND,
		S_SHIFT_RD,
		S_SHIFT_EX,
		S_HEAD,
		S_REBUILD_RD,
		S_REBUILD_EX,
		S_DONE
	} crr_state_t;

	typedef struct packed {
		logic [OFS_W-1:0] offset;
		logic [15:0]      length;
		logic [31:0]      base;
	} crr_entry_t;

	typedef struct packed {
		crr_op_t     op;
		logic [31:0] addr;
		logic [15:0] bytes;
		logic [1:0]  player;
	} crr_cmd_t;

	typedef struct packed {
		crr_status_t     status;
		logic [SA_W-1:0] store_address;
		logic [15:0]     lost_count;
	} crr_rsp_t;

	// Length rounded up to a whole word of four bytes.
	function automatic logic [OFS_W-1:0] round4(input logic [15:0] n);
		logic [16:0] r;
		r = (17'(n) + 17'd3) & ~17'd3;
		return r[OFS_W-1:0];
	endfunction

endpackage

// ===== src/crr_ram.sv =====
module crr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/crr_seq.sv =====
module crr_seq import crr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  crr_cmd_t cmd,
	output logic     ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output crr_rsp_t rsp
);

	crr_state_t state_q, state_d;

	crr_cmd_t         cmd_q;
	logic [CNT_W-1:0] cnt_q, k_q, ins_q;
	logic [OFS_W-1:0] bytes_used_q, acc_q;
	logic             frozen_q, found_ins_q;
	logic [IDX_W-1:0] last_hit_q;
	logic [15:0]      refused_q;
	crr_entry_t       prev_q, next_q;
	logic             mn_q, mp_q, up_q;
	logic [15:0]      len1_q;
	crr_status_t      status_q;
	logic [SA_W-1:0]  where_q;

	logic             rd_en, wr_en;
	logic [IDX_W-1:0] rd_addr, wr_addr;
	crr_entry_t       wr_data, rd_data;
	logic [$bits(crr_entry_t)-1:0] rd_word;

	crr_ram #(.WIDTH($bits(crr_entry_t)), .DEPTH(MAX_ENTRIES)) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_word)
	);
	assign rd_data = crr_entry_t'(rd_word);

	// Covering test on the entry just read, free of wrap.
	logic [32:0] item_end, entry_end;
	logic        cov;
	logic [SA_W-1:0] where_c;
	assign item_end  = {1'b0, cmd_q.addr} + 33'(cmd_q.bytes);
	assign entry_end = {1'b0, rd_data.base} + 33'(rd_data.length);
	assign cov       = (cmd_q.addr >= rd_data.base) && (item_end <= entry_end);
	assign where_c   = SA_W'(32'(cmd_q.player) * STORE_BYTES) + SA_W'(rd_data.offset)
		+ SA_W'(cmd_q.addr - rd_data.base);

	// Merge decisions, taken once the scan has found the insertion point.
	logic        has_next, has_prev, mn_c, mp_c, full_c, up_c, down_c, shift_c;
	logic [16:0] len1_c;
	assign has_next = ins_q < cnt_q;
	assign has_prev = ins_q != '0;
	assign mn_c = has_next && (item_end == {1'b0, next_q.base})
		&& (17'(cmd_q.bytes) + 17'(next_q.length) <= 17'(MERGE_LIMIT));
	assign len1_c = mn_c ? 17'(cmd_q.bytes) + 17'(next_q.length) : 17'(cmd_q.bytes);
	assign mp_c = has_prev
		&& ({1'b0, prev_q.base} + 33'(prev_q.length) == {1'b0, cmd_q.addr})
		&& (17'(prev_q.length) + len1_c <= 17'(MERGE_LIMIT));
	assign full_c = (cnt_q >= CNT_W'(MAX_ENTRIES))
		|| (17'(bytes_used_q) + 17'(cmd_q.bytes) > 17'(STORE_BYTES));
	assign up_c    = !mn_c && !mp_c;
	assign down_c  = mn_c && mp_c;
	assign shift_c = up_c ? has_next : (down_c && (ins_q + CNT_W'(1) < cnt_q));

	logic [CNT_W-1:0] k_inc, k_dec, ins_dec;
	assign k_inc   = k_q + CNT_W'(1);
	assign k_dec   = k_q - CNT_W'(1);
	assign ins_dec = ins_q - CNT_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd.op)
						OP_REGISTER: state_d = S_SCAN_RD;
						OP_LOOKUP: begin
							if (32'(cmd.player) >= PLAYERS) begin
								state_d = S_DONE;
							end else if (CNT_W'(last_hit_q) < cnt_q) begin
								state_d = S_HIT_RD;
							end else begin
								state_d = S_SCAN_RD;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_SCAN_RD: begin
				if (k_q == cnt_q) begin
					state_d = (cmd_q.op == OP_REGISTER) ? S_DECIDE : S_DONE;
				end else begin
					state_d = S_SCAN_EX;
				end
			end
			S_SCAN_EX:    state_d = cov ? S_DONE : S_SCAN_RD;
			S_HIT_RD:     state_d = S_HIT_EX;
			S_HIT_EX:     state_d = cov ? S_DONE : S_SCAN_RD;
			S_DECIDE: begin
				if (full_c) begin
					state_d = S_DONE;
				end else if (frozen_q) begin
					state_d = S_APPEND;
				end else begin
					state_d = shift_c ? S_SHIFT_RD : S_HEAD;
				end
			end
			S_APPEND:     state_d = S_DONE;
			S_SHIFT_RD:   state_d = S_SHIFT_EX;
			S_SHIFT_EX: begin
				if (up_q ? (k_q == ins_q) : (k_inc == cnt_q)) begin
					state_d = S_HEAD;
				end else begin
					state_d = S_SHIFT_RD;
				end
			end
			S_HEAD:       state_d = S_REBUILD_RD;
			S_REBUILD_RD: state_d = (k_q == cnt_q) ? S_DONE : S_REBUILD_EX;
			S_REBUILD_EX: state_d = S_REBUILD_RD;
			S_DONE:       state_d = rsp_ready ? S_IDLE : S_DONE;
			default:      state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ready     = state_q == S_IDLE;
		rsp_valid = state_q == S_DONE;
		rd_en     = 1'b0;
		rd_addr   = k_q[IDX_W-1:0];
		wr_en     = 1'b0;
		wr_addr   = k_q[IDX_W-1:0];
		wr_data   = rd_data;
		case (state_q)
			S_SCAN_RD:    rd_en = k_q != cnt_q;
			S_HIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = last_hit_q;
			end
			S_SHIFT_RD:   rd_en = 1'b1;
			S_REBUILD_RD: rd_en = k_q != cnt_q;
			S_SHIFT_EX: begin
				wr_en   = 1'b1;
				wr_addr = up_q ? k_inc[IDX_W-1:0] : k_dec[IDX_W-1:0];
			end
			S_APPEND: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q[IDX_W-1:0];
				wr_data = '{offset: bytes_used_q, length: cmd_q.bytes, base: cmd_q.addr};
			end
			S_HEAD: begin
				wr_en = 1'b1;
				if (mp_q) begin
					wr_addr = ins_dec[IDX_W-1:0];
					wr_data = '{offset: '0, length: prev_q.length + len1_q, base: prev_q.base};
				end else begin
					wr_addr = ins_q[IDX_W-1:0];
					wr_data = '{offset: '0, length: len1_q, base: cmd_q.addr};
				end
			end
			S_REBUILD_EX: begin
				wr_en          = 1'b1;
				wr_data.offset = acc_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			bytes_used_q <= '0;
			frozen_q     <= 1'b0;
			last_hit_q   <= '0;
			refused_q    <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q       <= cmd;
						k_q         <= '0;
						ins_q       <= '0;
						found_ins_q <= 1'b0;
						where_q     <= '0;
						status_q    <= ST_NOT_FOUND;
						if (cmd.op == OP_FREEZE) begin
							frozen_q <= 1'b1;
							status_q <= ST_FROZEN;
						end
					end
				end
				S_SCAN_EX: begin
					k_q <= k_inc;
					if (cmd_q.op == OP_REGISTER) begin
						if (cov) begin
							status_q <= ST_COVERED;
						end
						if (!found_ins_q) begin
							if (rd_data.base >= cmd_q.addr) begin
								found_ins_q <= 1'b1;
								next_q      <= rd_data;
							end else begin
								ins_q  <= k_inc;
								prev_q <= rd_data;
							end
						end
					end else if (cov) begin
						status_q   <= ST_FOUND;
						where_q    <= where_c;
						last_hit_q <= k_q[IDX_W-1:0];
					end
				end
				S_HIT_EX: begin
					k_q <= '0;
					if (cov) begin
						status_q <= ST_FOUND;
						where_q  <= where_c;
					end
				end
				S_DECIDE: begin
					mn_q   <= mn_c;
					mp_q   <= mp_c;
					up_q   <= up_c;
					len1_q <= len1_c[15:0];
					k_q    <= up_c ? cnt_q - CNT_W'(1) : ins_q + CNT_W'(1);
					if (full_c) begin
						status_q <= ST_REFUSED;
						if (refused_q != '1) begin
							refused_q <= refused_q + 16'd1;
						end
					end else begin
						status_q <= ST_ADDED;
					end
				end
				S_APPEND: begin
					cnt_q        <= cnt_q + CNT_W'(1);
					bytes_used_q <= bytes_used_q + round4(cmd_q.bytes);
				end
				S_SHIFT_EX: begin
					k_q <= up_q ? k_dec : k_inc;
				end
				S_HEAD: begin
					cnt_q <= cnt_q + CNT_W'(1) - CNT_W'(mn_q) - CNT_W'(mp_q);
					k_q   <= '0;
					acc_q <= '0;
				end
				S_REBUILD_RD: begin
					if (k_q == cnt_q) begin
						bytes_used_q <= acc_q;
					end
				end
				S_REBUILD_EX: begin
					acc_q <= acc_q + round4(rd_data.length);
					k_q   <= k_inc;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

	assign rsp = '{status: status_q, store_address: where_q, lost_count: refused_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count beyond table size");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_DONE) |-> !wr_en)
		else $error("table written outside an operation");

	a_store_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(bytes_used_q) <= STORE_BYTES + 3)
		else $error("store use beyond backing store");

	a_freeze_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		$past(frozen_q) |-> frozen_q)
		else $error("layout unfroze");

endmodule

// ===== src/coalescing_region_registry_top.sv =====
// Region registry: keeps up to 64 byte-address regions, each with a place in
// a per-player backing store of 1024 bytes. Every transfer on the input side
// yields exactly one result transfer. The table lives in a single synchronous
// RAM; registrations and lookups walk it one entry at a time, each entry
// access having an address step and then a data step. A lookup first checks
// the entry of the previous hit, if still stored, and otherwise scans the
// table. A registration scans the table, then, before the layout is frozen,
// shifts entries to open or close a gap and rebuilds every offset; after the
// freeze it is appended after the scan. A freeze does not walk the table.
// One item is worked on at a time; the result sits in an output register so
// the next item may be taken while it waits.
module coalescing_region_registry_top import crr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // region_address, region_bytes, player, zero pad
	input  logic [1:0]  s_axis_tuser,  // operation
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // store_address, lost_count, zero pad
	output logic [2:0]  m_axis_tuser   // status
);

	crr_cmd_t cmd;
	crr_rsp_t rsp, rsp_q;
	logic     start, seq_ready, rsp_valid, rsp_ready, out_valid_q;

	// Unpack the input transfer into its fields.
	assign cmd.op     = crr_op_t'(s_axis_tuser);
	assign cmd.addr   = s_axis_tdata[31:0];
	assign cmd.bytes  = s_axis_tdata[47:32];
	assign cmd.player = s_axis_tdata[49:48];

	assign s_axis_tready = seq_ready;
	assign start         = s_axis_tvalid && seq_ready;

	crr_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.ready     (seq_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	// Output register: the sequencer hands its result over as soon as the
	// register is empty or is being emptied in the same cycle.
	assign rsp_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rsp_ready) begin
			out_valid_q <= rsp_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_valid && rsp_ready) begin
			rsp_q <= rsp;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = rsp_q.status;
	assign m_axis_tdata  = {4'd0, rsp_q.lost_count, rsp_q.store_address};

endmodule
